@@ rtl/core/lftrp_pkg.sv @@
`default_nettype none

package lftrp_pkg;

    // special byte values on the reader link
    localparam logic [7:0] LF_BYTE    = 8'h0A;
    localparam logic [7:0] CR_BYTE    = 8'h0D;
    localparam logic [7:0] ERR_BYTE   = 8'h58;
    localparam logic [7:0] NOTAG_BYTE = 8'h51;

    // long frame window: bytes TAG_FIRST .. LONG_MIN_LEN-1
    localparam int LONG_MIN_LEN = 29;
    localparam int TAG_FIRST    = 5;

    // run index width, holds 0 .. LONG_MIN_LEN
    localparam int IDX_W = 5;

    // result kinds
    typedef enum logic [2:0] {
        KIND_TAG   = 3'd0,
        KIND_SHORT = 3'd1,
        KIND_ERR   = 3'd2,
        KIND_NOTAG = 3'd3,
        KIND_EMPTY = 3'd4
    } t_kind;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_SEND
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic byte_acc;
        logic load_single;
        logic start_run;
        logic load_result;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_close;
        logic is_single;
        logic out_last;
    } t_dp_sts;

endpackage

`default_nettype wire

@@ rtl/core/lftrp_dp.sv @@
`default_nettype none

module lftrp_dp #(
    parameter int BUF_SIZE = 64
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire  [7:0]            i_rx_byte,
    input  lftrp_pkg::t_dp_cmd    i_cmd,
    output lftrp_pkg::t_dp_sts    o_sts,
    output logic [2:0]            o_kind,
    output logic [7:0]            o_data_byte,
    output logic                  o_last
);

    localparam int DEPTH = BUF_SIZE - 1;
    localparam int PW    = $clog2(BUF_SIZE);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = lftrp_pkg::IDX_W;

    // frame store
    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    // frame tracking
    logic          r_frame_open, n_frame_open;
    logic [PW-1:0] r_wr_pos,     n_wr_pos;
    logic [PW-1:0] r_len,        n_len;
    logic          r_zero_seen,  n_zero_seen;
    logic [7:0]    r_first,      n_first;

    // run control
    logic [IW-1:0]     r_rd_idx, n_rd_idx;
    logic [IW-1:0]     r_end,    n_end;
    lftrp_pkg::t_kind  r_kind,   n_kind;

    // output register
    lftrp_pkg::t_kind  r_out_kind, n_out_kind;
    logic [7:0]        r_out_data, n_out_data;
    logic              r_out_last, n_out_last;

    logic              is_lf;
    logic              is_cr;
    logic              store_en;
    logic              is_long;
    lftrp_pkg::t_kind  single_kind;
    logic [AW-1:0]     rd_addr;

    // byte decode and close classification
    always_comb begin
        is_lf    = (i_rx_byte == lftrp_pkg::LF_BYTE);
        is_cr    = (i_rx_byte == lftrp_pkg::CR_BYTE);
        store_en = i_cmd.byte_acc && !is_lf && !is_cr && r_frame_open
                   && (r_wr_pos < PW'(DEPTH));
        is_long  = (int'(r_len) >= lftrp_pkg::LONG_MIN_LEN);
        if (r_len == '0) begin
            single_kind = lftrp_pkg::KIND_EMPTY;
        end else if (r_first == lftrp_pkg::ERR_BYTE) begin
            single_kind = lftrp_pkg::KIND_ERR;
        end else begin
            single_kind = lftrp_pkg::KIND_NOTAG;
        end
        o_sts.is_close  = is_lf && r_frame_open;
        o_sts.is_single = (r_len == '0)
                          || ((r_len == PW'(1))
                              && ((r_first == lftrp_pkg::ERR_BYTE)
                                  || (r_first == lftrp_pkg::NOTAG_BYTE)));
        o_sts.out_last  = r_out_last;
        rd_addr         = AW'(r_rd_idx);
    end

    // next state of frame tracking, run and output registers
    always_comb begin
        n_frame_open = r_frame_open;
        n_wr_pos     = r_wr_pos;
        n_len        = r_len;
        n_zero_seen  = r_zero_seen;
        n_first      = r_first;
        n_rd_idx     = r_rd_idx;
        n_end        = r_end;
        n_kind       = r_kind;
        n_out_kind   = r_out_kind;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;

        if (i_cmd.byte_acc && is_lf) begin
            if (!r_frame_open) begin
                n_frame_open = 1'b1;
                n_wr_pos     = '0;
                n_len        = '0;
                n_zero_seen  = 1'b0;
            end else begin
                n_frame_open = 1'b0;
                n_wr_pos     = '0;
            end
        end else if (store_en) begin
            n_wr_pos = r_wr_pos + PW'(1);
            if (r_wr_pos == '0) begin
                n_first = i_rx_byte;
            end
            if (i_rx_byte == 8'h00) begin
                n_zero_seen = 1'b1;
            end else if (!r_zero_seen) begin
                n_len = r_len + PW'(1);
            end
        end

        if (i_cmd.load_single) begin
            n_out_kind = single_kind;
            n_out_data = 8'h00;
            n_out_last = 1'b1;
        end

        if (i_cmd.start_run) begin
            if (is_long) begin
                n_rd_idx = IW'(lftrp_pkg::TAG_FIRST);
                n_end    = IW'(lftrp_pkg::LONG_MIN_LEN);
                n_kind   = lftrp_pkg::KIND_TAG;
            end else begin
                n_rd_idx = '0;
                n_end    = IW'(r_len);
                n_kind   = lftrp_pkg::KIND_SHORT;
            end
        end

        if (i_cmd.load_result) begin
            n_out_kind = r_kind;
            n_out_data = r_rd_data;
            n_out_last = ((r_rd_idx + IW'(1)) == r_end);
            n_rd_idx   = r_rd_idx + IW'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_open <= 1'b0;
            r_wr_pos     <= '0;
            r_len        <= '0;
            r_zero_seen  <= 1'b0;
            r_rd_idx     <= '0;
            r_end        <= '0;
        end else begin
            r_frame_open <= n_frame_open;
            r_wr_pos     <= n_wr_pos;
            r_len        <= n_len;
            r_zero_seen  <= n_zero_seen;
            r_rd_idx     <= n_rd_idx;
            r_end        <= n_end;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_first    <= n_first;
        r_kind     <= n_kind;
        r_out_kind <= n_out_kind;
        r_out_data <= n_out_data;
        r_out_last <= n_out_last;
    end

    // store write and registered read
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[r_wr_pos[AW-1:0]] <= i_rx_byte;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    assign o_kind      = r_out_kind;
    assign o_data_byte = r_out_data;
    assign o_last      = r_out_last;

    // write position never runs past the store
    a_wr_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_pos <= PW'(DEPTH))
        else $error("write position beyond store");

    // content never longer than what was stored
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frame_open |-> (r_len <= r_wr_pos))
        else $error("content length exceeds stored bytes");

    // closed frame holds no write position
    a_closed_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_frame_open |-> (r_wr_pos == '0))
        else $error("write position set with no frame open");

endmodule

`default_nettype wire

@@ rtl/core/lftrp_ctrl.sv @@
`default_nettype none

module lftrp_ctrl (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    output logic                  o_valid,
    input  wire                   i_stall,
    input  lftrp_pkg::t_dp_sts    i_sts,
    output lftrp_pkg::t_dp_cmd    o_cmd
);

    lftrp_pkg::t_state r_state, n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lftrp_pkg::ST_IDLE: begin
                if (i_valid && i_sts.is_close) begin
                    n_state = i_sts.is_single ? lftrp_pkg::ST_SEND : lftrp_pkg::ST_FETCH;
                end
            end
            lftrp_pkg::ST_FETCH: begin
                n_state = lftrp_pkg::ST_LOAD;
            end
            lftrp_pkg::ST_LOAD: begin
                n_state = lftrp_pkg::ST_SEND;
            end
            lftrp_pkg::ST_SEND: begin
                if (!i_stall) begin
                    n_state = i_sts.out_last ? lftrp_pkg::ST_IDLE : lftrp_pkg::ST_FETCH;
                end
            end
            default: begin
                n_state = lftrp_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb begin
        o_stall           = 1'b1;
        o_valid           = 1'b0;
        o_cmd.byte_acc    = 1'b0;
        o_cmd.load_single = 1'b0;
        o_cmd.start_run   = 1'b0;
        o_cmd.load_result = 1'b0;
        case (r_state)
            lftrp_pkg::ST_IDLE: begin
                o_stall        = 1'b0;
                o_cmd.byte_acc = i_valid;
                if (i_valid && i_sts.is_close) begin
                    o_cmd.load_single = i_sts.is_single;
                    o_cmd.start_run   = !i_sts.is_single;
                end
            end
            lftrp_pkg::ST_LOAD: begin
                o_cmd.load_result = 1'b1;
            end
            lftrp_pkg::ST_SEND: begin
                o_valid = 1'b1;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lftrp_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // never take a byte while a result is shown
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && !o_stall))
        else $error("input taken while result pending");

    // final result of a run returns to idle
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && i_sts.out_last) |=> (r_state == lftrp_pkg::ST_IDLE))
        else $error("run did not end on last result");

    // a closing byte starts exactly one kind of response
    a_one_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_single && o_cmd.start_run))
        else $error("single result and run started together");

endmodule

`default_nettype wire

@@ rtl/core/lf_framed_tag_reply_parser.sv @@
`default_nettype none

// channel   | valid    | stall    | payload
// ----------+----------+----------+-----------------------------------
// rx item   | i_valid  | o_stall  | i_rx_byte
// result    | o_valid  | i_stall  | o_kind, o_data_byte, o_last
//
// a byte that closes no frame is taken in idle; a closing line feed is
// taken in idle too, then a single-result frame goes straight to show,
// and each run result (up to 28) passes fetch, load and show (store read,
// output load, show), set by the frame store's single registered read port.
// reset is synchronous and active low; the store needs no clearing.
// while a run is shown, o_stall stays high; i_stall holds a result in place.

module lf_framed_tag_reply_parser #(
    parameter int BUF_SIZE = 64
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [7:0]  i_rx_byte,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [2:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last
);

    lftrp_pkg::t_dp_cmd dp_cmd;
    lftrp_pkg::t_dp_sts dp_sts;

    // sequencing of byte intake and result runs
    lftrp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (dp_sts),
        .o_cmd   (dp_cmd)
    );

    // frame store, counters and output register
    lftrp_dp #(
        .BUF_SIZE (BUF_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_byte   (i_rx_byte),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

@@ bench/lftrp_reply_checker.sv @@
`timescale 1ns / 100ps

module lftrp_reply_checker #(
    parameter int BUF_SIZE = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_rx_valid,
    input  wire        i_rx_stall,
    input  wire  [7:0] i_rx_byte,
    input  wire        i_res_valid,
    input  wire        i_res_stall,
    input  wire  [2:0] i_kind,
    input  wire  [7:0] i_data_byte,
    input  wire        i_last,
    output int         o_fail_count,
    output int         o_pending
);

    typedef struct packed {
        lftrp_pkg::t_kind kind;
        logic [7:0]       data_byte;
        logic             last;
    } t_reply;

    // shadow of the parser state
    bit          in_frame;
    int unsigned stored_cnt;
    int unsigned text_len;
    bit          zero_hit;
    logic [7:0]  frame_copy [0:BUF_SIZE-2];

    // replies still to come, oldest first
    t_reply replies_due [$];

    task automatic queue_reply(input lftrp_pkg::t_kind kind, input logic [7:0] data_byte,
                               input logic last);
        t_reply r;
        begin
            r.kind      = kind;
            r.data_byte = data_byte;
            r.last      = last;
            replies_due.push_back(r);
        end
    endtask

    // frame close: work out the whole run of replies
    task automatic predict_close();
        int i;
        begin
            in_frame   = 1'b0;
            stored_cnt = 0;
            if (text_len == 1 && frame_copy[0] == lftrp_pkg::ERR_BYTE)
                queue_reply(lftrp_pkg::KIND_ERR, 8'h00, 1'b1);
            else if (text_len == 1 && frame_copy[0] == lftrp_pkg::NOTAG_BYTE)
                queue_reply(lftrp_pkg::KIND_NOTAG, 8'h00, 1'b1);
            else if (text_len == 0)
                queue_reply(lftrp_pkg::KIND_EMPTY, 8'h00, 1'b1);
            else if (text_len >= lftrp_pkg::LONG_MIN_LEN) begin
                for (i = lftrp_pkg::TAG_FIRST; i < lftrp_pkg::LONG_MIN_LEN; i++)
                    queue_reply(lftrp_pkg::KIND_TAG, frame_copy[i],
                                i == lftrp_pkg::LONG_MIN_LEN - 1);
            end else begin
                for (i = 0; i < text_len; i++)
                    queue_reply(lftrp_pkg::KIND_SHORT, frame_copy[i], i == text_len - 1);
            end
        end
    endtask

    // one accepted byte from the reader link
    task automatic absorb_byte(input logic [7:0] b);
        begin
            if (b == lftrp_pkg::LF_BYTE) begin
                if (!in_frame) begin
                    in_frame   = 1'b1;
                    stored_cnt = 0;
                    text_len   = 0;
                    zero_hit   = 1'b0;
                    foreach (frame_copy[i]) frame_copy[i] = 8'h00;
                end else begin
                    predict_close();
                end
            end else if (b != lftrp_pkg::CR_BYTE && in_frame
                         && stored_cnt < BUF_SIZE - 1) begin
                frame_copy[stored_cnt] = b;
                stored_cnt++;
                if (b == 8'h00)
                    zero_hit = 1'b1;
                else if (!zero_hit)
                    text_len++;
            end
        end
    endtask

    // compare one accepted result item with the oldest reply due
    task automatic check_reply();
        t_reply want;
        begin
            if (replies_due.size() == 0) begin
                $display("%0t: result with none expected: kind %0d data %02h last %0b",
                         $time, i_kind, i_data_byte, i_last);
                o_fail_count++;
            end else begin
                want = replies_due.pop_front();
                if (i_kind !== want.kind) begin
                    $display("%0t: kind expected %0d actual %0d",
                             $time, want.kind, i_kind);
                    o_fail_count++;
                end
                if (i_data_byte !== want.data_byte) begin
                    $display("%0t: data_byte expected %02h actual %02h",
                             $time, want.data_byte, i_data_byte);
                    o_fail_count++;
                end
                if (i_last !== want.last) begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, i_last);
                    o_fail_count++;
                end
            end
        end
    endtask

    // results accepted at this edge belong to earlier items, so check first
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_frame   = 1'b0;
            stored_cnt = 0;
            text_len   = 0;
            zero_hit   = 1'b0;
            replies_due.delete();
        end else begin
            if (i_res_valid && !i_res_stall)
                check_reply();
            if (i_rx_valid && !i_rx_stall)
                absorb_byte(i_rx_byte);
        end
        o_pending = replies_due.size();
    end

endmodule

@@ bench/lf_framed_tag_reply_parser_tb.sv @@
`timescale 1ns / 100ps

module lf_framed_tag_reply_parser_tb;

    localparam int BUF_SIZE = 64;
    localparam int RX_ITEMS = 350;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic [2:0] o_kind;
    logic [7:0] o_data_byte;
    logic       o_last;

    int fail_count;
    int replies_pending;

    bit calm     = 0;
    bit gaps_on  = 1;
    int items_done = 0;
    int stall_left = 0;
    int quiet_left = 0;

    logic [7:0] opening_bytes [0:21];

    lf_framed_tag_reply_parser #(
        .BUF_SIZE (BUF_SIZE)
    ) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_rx_byte   (i_rx_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_data_byte (o_data_byte),
        .o_last      (o_last)
    );

    lftrp_reply_checker #(
        .BUF_SIZE (BUF_SIZE)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rx_valid   (i_valid),
        .i_rx_stall   (o_stall),
        .i_rx_byte    (i_rx_byte),
        .i_res_valid  (o_valid),
        .i_res_stall  (i_stall),
        .i_kind       (o_kind),
        .i_data_byte  (o_data_byte),
        .i_last       (o_last),
        .o_fail_count (fail_count),
        .o_pending    (replies_pending)
    );

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // result side back-pressure: bursts, with quiet stretches
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            i_stall = 1'b1;
            stall_left--;
        end else if (quiet_left > 0 || calm) begin
            i_stall = 1'b0;
            if (quiet_left > 0) quiet_left--;
        end else begin
            case ($urandom_range(0, 15))
                0, 1, 2: begin
                    i_stall    = 1'b1;
                    stall_left = $urandom_range(0, 12);
                end
                3: begin
                    i_stall    = 1'b0;
                    quiet_left = $urandom_range(20, 80);
                end
                default: i_stall = 1'b0;
            endcase
        end
    end

    // hand one byte over, with an optional gap before it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        begin
            if (gaps_on && !calm && $urandom_range(0, 4) == 0) begin
                gap     = $urandom_range(1, 13);
                i_valid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_valid   = 1'b1;
            i_rx_byte = b;
            @(posedge i_clk);
            while (o_stall) @(posedge i_clk);
            @(negedge i_clk);
        end
    endtask

    // any byte that is not a line feed
    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        begin
            b = 8'($urandom_range(0, 255));
            while (b == lftrp_pkg::LF_BYTE) b = 8'($urandom_range(0, 255));
            return b;
        end
    endfunction

    // a complete frame with random content, no zero byte unless asked
    task automatic send_frame(input int body_len, input bit cr_noise, input bit with_zero);
        int         zero_at;
        int         i;
        logic [7:0] b;
        begin
            zero_at = (with_zero && body_len > 0) ? $urandom_range(0, body_len - 1) : -1;
            send_byte(lftrp_pkg::LF_BYTE);
            for (i = 0; i < body_len; i++) begin
                if (cr_noise && $urandom_range(0, 7) == 0) begin
                    send_byte(lftrp_pkg::CR_BYTE);
                    items_done++;
                end
                if (i == zero_at)
                    b = 8'h00;
                else begin
                    b = text_byte();
                    while (b == 8'h00) b = text_byte();
                end
                send_byte(b);
            end
            if (cr_noise) begin
                send_byte(lftrp_pkg::CR_BYTE);
                items_done++;
            end
            send_byte(lftrp_pkg::LF_BYTE);
            items_done += body_len + 2;
        end
    endtask

    // stimulus
    initial begin
        int         i;
        int         n;
        logic [7:0] b;
        i_rst_n   = 1'b0;
        i_valid   = 1'b0;
        i_rx_byte = 8'h00;
        i_stall   = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // noise outside a frame, reader error, no tag, empty, zero-only,
        // no tag between carriage returns, extreme bytes cut by a zero,
        // reader error followed by hidden bytes after a zero
        opening_bytes = '{8'hFF, lftrp_pkg::LF_BYTE, lftrp_pkg::ERR_BYTE,
                          lftrp_pkg::LF_BYTE,
                          lftrp_pkg::LF_BYTE, lftrp_pkg::NOTAG_BYTE, lftrp_pkg::LF_BYTE,
                          lftrp_pkg::LF_BYTE, lftrp_pkg::LF_BYTE,
                          lftrp_pkg::LF_BYTE, 8'h00, lftrp_pkg::LF_BYTE,
                          lftrp_pkg::LF_BYTE, lftrp_pkg::CR_BYTE, lftrp_pkg::NOTAG_BYTE,
                          lftrp_pkg::CR_BYTE, lftrp_pkg::LF_BYTE,
                          lftrp_pkg::LF_BYTE, 8'hFF, 8'h00, 8'h01, lftrp_pkg::LF_BYTE};
        for (i = 0; i < 22; i++) send_byte(opening_bytes[i]);
        send_byte(lftrp_pkg::LF_BYTE);
        send_byte(lftrp_pkg::ERR_BYTE);
        send_byte(8'h00);
        send_byte(lftrp_pkg::NOTAG_BYTE);
        send_byte(lftrp_pkg::LF_BYTE);
        items_done = 27;

        // one long frame and one that overruns the store
        send_frame(34, 1'b0, 1'b0);
        send_frame(70, 1'b1, 1'b0);

        while (items_done < RX_ITEMS) begin
            if (items_done >= RX_ITEMS - 60) calm = 1;
            gaps_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 11))
                0: send_frame(0, 1'($urandom_range(0, 1)), 1'b0);
                1, 2: begin
                    // single byte frame: mostly the two special answers
                    case ($urandom_range(0, 2))
                        0: b = lftrp_pkg::ERR_BYTE;
                        1: b = lftrp_pkg::NOTAG_BYTE;
                        default: b = text_byte();
                    endcase
                    send_byte(lftrp_pkg::LF_BYTE);
                    send_byte(b);
                    send_byte(lftrp_pkg::LF_BYTE);
                    items_done += 3;
                end
                3, 4, 5, 6: send_frame($urandom_range(2, 28), 1'($urandom_range(0, 1)),
                                       $urandom_range(0, 5) == 0);
                7, 8: send_frame($urandom_range(29, 45), 1'($urandom_range(0, 1)),
                                 $urandom_range(0, 5) == 0);
                9: send_frame($urandom_range(60, 75), 1'($urandom_range(0, 1)),
                              $urandom_range(0, 5) == 0);
                default: begin
                    // stray bytes between frames
                    n = $urandom_range(1, 4);
                    repeat (n) send_byte(text_byte());
                    items_done += n;
                end
            endcase
        end
        i_valid = 1'b0;

        wait (replies_pending == 0);
        repeat (100) @(posedge i_clk);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // run limit
    initial begin
        #2000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
